// File: rtl/cbpo_pkg.sv
package cbpo_pkg;

  // Fixed-point format of positions and results
  localparam int FRAC_BITS = 16;
  // Radius register width; offsets that can still overlap fit in it
  localparam int RW  = 17;
  // Width of squares, products and quotients
  localparam int QW  = 2 * RW;
  // Result width
  localparam int PW  = 32;
  // Width of the centre offset from the square's low corner
  localparam int CW  = ((PW > 16 + FRAC_BITS) ? PW : 16 + FRAC_BITS) + 3;
  // Width of the offset from the square's middle (only used when inside)
  localparam int EW  = FRAC_BITS + 2;
  // Square-root partial remainder width
  localparam int RMW = RW + 2;

  // Stage map
  localparam int S_REL = 0;
  localparam int S_OFF = 1;
  localparam int S_SQR = 2;
  localparam int S_SUM = 3;
  localparam int S_SQ0 = 4;
  localparam int S_GAP = S_SQ0 + RW;
  localparam int S_DV0 = S_GAP + 1;
  localparam int S_OUT = S_DV0 + QW;

  localparam logic [RW-1:0] RADIUS_RST = RW'(13107);

  typedef struct packed {
    logic signed [CW-1:0] relx;
    logic signed [CW-1:0] relz;
    logic [RW-1:0]        r;
    logic                 near;
    logic                 sx;
    logic                 sz;
    logic                 zx;
    logic                 zz;
    logic [RW-1:0]        ax;
    logic [RW-1:0]        az;
    logic signed [EW-1:0] ex;
    logic signed [EW-1:0] ez;
    logic [QW-1:0]        sqx;
    logic [QW-1:0]        sqz;
    logic [QW-1:0]        r2;
    logic                 hit;
    logic                 diag;
    logic signed [PW-1:0] qx;
    logic signed [PW-1:0] qz;
    logic [QW-1:0]        rad;
    logic [RMW-1:0]       rem;
    logic [RW-1:0]        root;
    logic [QW-1:0]        numx;
    logic [QW-1:0]        numz;
    logic [RW-1:0]        remx;
    logic [RW-1:0]        remz;
  } pipe_t;

endpackage

// File: rtl/circle_box_push_out.sv
// Circle versus unit-square push-out. Each request carries the integer low corner of a unit
// square and a circle centre in signed fixed point; the result is the correction that moves
// a circle of radius min_distance clear of the square, plus a hit flag. The block is a
// 57-register pipeline: offset and clamp (2 stages), squaring, sum and compare, a 17-stage
// square root (one root bit per stage), the gap multiply, a 34-stage restoring divider (one
// quotient bit per stage, x and z side by side) and the output register. It takes one request
// per clock while the output is not stalled and returns results in request order; a stall at
// the output holds only as many stages as are full. min_distance may be written only while no
// request is in flight.
module circle_box_push_out (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [16:0]         cfg_wdata_i,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic signed [15:0]  box_x_i,
  input  logic signed [15:0]  box_z_i,
  input  logic signed [31:0]  pos_x_i,
  input  logic signed [31:0]  pos_z_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [31:0]  push_x_o,
  output logic signed [31:0]  push_z_o,
  output logic                hit_o
);

  localparam int NS = cbpo_pkg::S_OUT;
  localparam int CW = cbpo_pkg::CW;
  localparam int RW = cbpo_pkg::RW;
  localparam int QW = cbpo_pkg::QW;
  localparam int PW = cbpo_pkg::PW;
  localparam int EW = cbpo_pkg::EW;
  localparam int RMW = cbpo_pkg::RMW;
  localparam int FB = cbpo_pkg::FRAC_BITS;

  localparam logic signed [CW-1:0] ONE_C  = CW'(64'd1 << FB);
  localparam logic signed [CW-1:0] HALF_C = CW'(64'd1 << (FB - 1));
  localparam logic signed [PW-1:0] HALF_P = PW'(64'd1 << (FB - 1));
  localparam logic [63:0] POS_LIM = 64'h0000_0000_7FFF_FFFF;
  localparam logic [63:0] NEG_LIM = 64'h0000_0000_8000_0000;

  function automatic logic signed [PW-1:0] axis_push(input logic signed [PW-1:0] off,
                                                     input logic signed [PW-1:0] reach);
    return (off < 0) ? (-reach - off) : (reach - off);
  endfunction

  logic [RW-1:0] min_distance_q;

  cbpo_pkg::pipe_t st_q [NS];
  cbpo_pkg::pipe_t st_d [NS];
  cbpo_pkg::pipe_t prv  [NS];
  logic [NS:0]     v_q;
  logic [NS:0]     adv;

  logic signed [PW-1:0] push_x_q, push_x_d;
  logic signed [PW-1:0] push_z_q, push_z_d;
  logic                 hit_q, hit_d;

  // Hold the radius register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_distance_q <= cbpo_pkg::RADIUS_RST;
    end else if (cfg_we_i) begin
      min_distance_q <= cfg_wdata_i;
    end
  end

  // Advance a stage when it is empty or the next stage advances
  always_comb begin
    adv[NS] = !v_q[NS] || out_ready_i;
    for (int k = NS - 1; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign in_ready_o = adv[0];

  // Move valid bits down the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) begin
        v_q[0] <= in_valid_i;
      end
      for (int k = 1; k <= NS; k++) begin
        if (adv[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  for (genvar k = 0; k < NS; k++) begin : g_stage
    if (k == 0) begin : g_first
      assign prv[k] = '0;
    end else begin : g_next
      assign prv[k] = st_q[k-1];
    end

    if (k == cbpo_pkg::S_REL) begin : g_rel
      // Offset of the centre from the square's low corner
      always_comb begin
        st_d[k]      = prv[k];
        st_d[k].r    = min_distance_q;
        st_d[k].relx = CW'(pos_x_i) - (CW'(box_x_i) <<< FB);
        st_d[k].relz = CW'(pos_z_i) - (CW'(box_z_i) <<< FB);
      end
    end else if (k == cbpo_pkg::S_OFF) begin : g_off
      // Clamp to the square and test each offset against the radius
      always_comb begin
        logic signed [CW-1:0] dx, dz, adx, adz;
        dx = (prv[k].relx < 0) ? prv[k].relx :
             ((prv[k].relx > ONE_C) ? prv[k].relx - ONE_C : '0);
        dz = (prv[k].relz < 0) ? prv[k].relz :
             ((prv[k].relz > ONE_C) ? prv[k].relz - ONE_C : '0);
        adx = (dx < 0) ? -dx : dx;
        adz = (dz < 0) ? -dz : dz;
        st_d[k]       = prv[k];
        st_d[k].near  = (adx < signed'(CW'(prv[k].r))) && (adz < signed'(CW'(prv[k].r)));
        st_d[k].sx    = dx < 0;
        st_d[k].sz    = dz < 0;
        st_d[k].zx    = dx == 0;
        st_d[k].zz    = dz == 0;
        st_d[k].ax    = adx[RW-1:0];
        st_d[k].az    = adz[RW-1:0];
        st_d[k].ex    = EW'(prv[k].relx - HALF_C);
        st_d[k].ez    = EW'(prv[k].relz - HALF_C);
      end
    end else if (k == cbpo_pkg::S_SQR) begin : g_sqr
      // Square the offsets and the radius
      always_comb begin
        st_d[k]     = prv[k];
        st_d[k].sqx = QW'(prv[k].ax) * QW'(prv[k].ax);
        st_d[k].sqz = QW'(prv[k].az) * QW'(prv[k].az);
        st_d[k].r2  = QW'(prv[k].r) * QW'(prv[k].r);
      end
    end else if (k == cbpo_pkg::S_SUM) begin : g_sum
      // Decide overlap and form the inside and axial pushes
      always_comb begin
        logic [QW:0]          d2;
        logic signed [PW-1:0] r32, reach, ex32, ez32, aex, aez, dx32, dz32;
        d2    = {1'b0, prv[k].sqx} + {1'b0, prv[k].sqz};
        r32   = signed'(PW'(prv[k].r));
        reach = r32 + HALF_P;
        ex32  = PW'(prv[k].ex);
        ez32  = PW'(prv[k].ez);
        aex   = (ex32 < 0) ? -ex32 : ex32;
        aez   = (ez32 < 0) ? -ez32 : ez32;
        dx32  = prv[k].sx ? -signed'(PW'(prv[k].ax)) : signed'(PW'(prv[k].ax));
        dz32  = prv[k].sz ? -signed'(PW'(prv[k].az)) : signed'(PW'(prv[k].az));
        st_d[k]      = prv[k];
        st_d[k].hit  = prv[k].near && (d2 < {1'b0, prv[k].r2});
        st_d[k].diag = !prv[k].zx && !prv[k].zz;
        st_d[k].qx   = '0;
        st_d[k].qz   = '0;
        if (prv[k].zx && prv[k].zz) begin
          if (aex > aez) begin
            st_d[k].qx = axis_push(ex32, reach);
          end else begin
            st_d[k].qz = axis_push(ez32, reach);
          end
        end else if (prv[k].zx) begin
          st_d[k].qz = axis_push(dz32, r32);
        end else if (prv[k].zz) begin
          st_d[k].qx = axis_push(dx32, r32);
        end
        st_d[k].rad  = d2[QW-1:0];
        st_d[k].rem  = '0;
        st_d[k].root = '0;
      end
    end else if (k < cbpo_pkg::S_GAP) begin : g_sqrt
      // One root bit per stage
      always_comb begin
        logic [RMW-1:0] remn, trial;
        remn  = {prv[k].rem[RW-1:0], prv[k].rad[QW-1 -: 2]};
        trial = {prv[k].root, 2'b01};
        st_d[k]     = prv[k];
        st_d[k].rad = {prv[k].rad[QW-3:0], 2'b00};
        if (remn >= trial) begin
          st_d[k].rem  = remn - trial;
          st_d[k].root = {prv[k].root[RW-2:0], 1'b1};
        end else begin
          st_d[k].rem  = remn;
          st_d[k].root = {prv[k].root[RW-2:0], 1'b0};
        end
      end
    end else if (k == cbpo_pkg::S_GAP) begin : g_gap
      // Scale each offset by the remaining gap
      always_comb begin
        logic [RW-1:0] gap;
        gap = prv[k].r - prv[k].root;
        st_d[k]      = prv[k];
        st_d[k].numx = QW'(prv[k].ax) * QW'(gap);
        st_d[k].numz = QW'(prv[k].az) * QW'(gap);
        st_d[k].remx = '0;
        st_d[k].remz = '0;
      end
    end else begin : g_div
      // One quotient bit per stage for both lanes
      always_comb begin
        logic [RW:0] rnx, rnz, dv;
        dv  = {1'b0, prv[k].root};
        rnx = {prv[k].remx, prv[k].numx[QW-1]};
        rnz = {prv[k].remz, prv[k].numz[QW-1]};
        st_d[k] = prv[k];
        if (rnx >= dv) begin
          st_d[k].remx = RW'(rnx - dv);
          st_d[k].numx = {prv[k].numx[QW-2:0], 1'b1};
        end else begin
          st_d[k].remx = rnx[RW-1:0];
          st_d[k].numx = {prv[k].numx[QW-2:0], 1'b0};
        end
        if (rnz >= dv) begin
          st_d[k].remz = RW'(rnz - dv);
          st_d[k].numz = {prv[k].numz[QW-2:0], 1'b1};
        end else begin
          st_d[k].remz = rnz[RW-1:0];
          st_d[k].numz = {prv[k].numz[QW-2:0], 1'b0};
        end
      end
    end

    // Load the stage when it advances
    always_ff @(posedge clk_i) begin
      if (adv[k]) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  // Select, sign and saturate the result
  always_comb begin
    logic [63:0] mx, mz;
    mx = 64'(st_q[NS-1].numx);
    mz = 64'(st_q[NS-1].numz);
    hit_d    = st_q[NS-1].hit;
    push_x_d = '0;
    push_z_d = '0;
    if (st_q[NS-1].hit) begin
      if (st_q[NS-1].diag) begin
        if (st_q[NS-1].sx) begin
          push_x_d = (mx >= NEG_LIM) ? NEG_LIM[PW-1:0] : -signed'(mx[PW-1:0]);
        end else begin
          push_x_d = (mx > POS_LIM) ? POS_LIM[PW-1:0] : mx[PW-1:0];
        end
        if (st_q[NS-1].sz) begin
          push_z_d = (mz >= NEG_LIM) ? NEG_LIM[PW-1:0] : -signed'(mz[PW-1:0]);
        end else begin
          push_z_d = (mz > POS_LIM) ? POS_LIM[PW-1:0] : mz[PW-1:0];
        end
      end else begin
        push_x_d = st_q[NS-1].qx;
        push_z_d = st_q[NS-1].qz;
      end
    end
  end

  // Hold the output register until taken
  always_ff @(posedge clk_i) begin
    if (adv[NS]) begin
      push_x_q <= push_x_d;
      push_z_q <= push_z_d;
      hit_q    <= hit_d;
    end
  end

  assign out_valid_o = v_q[NS];
  assign push_x_o    = push_x_q;
  assign push_z_o    = push_z_q;
  assign hit_o       = hit_q;

endmodule

// File: rtl/cbpo_checker.sv
module cbpo_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               cfg_we_i,
  input logic [16:0]        cfg_wdata_i,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic signed [15:0] box_x_i,
  input logic signed [15:0] box_z_i,
  input logic signed [31:0] pos_x_i,
  input logic signed [31:0] pos_z_i,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input logic signed [31:0] push_x_o,
  input logic signed [31:0] push_z_o,
  input logic               hit_o
);

  // No result is shown right after reset is sampled active
  a_rst_quiet: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("result valid during reset");

  // A miss carries a zero push
  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !hit_o |-> push_x_o == 0 && push_z_o == 0)
    else $error("nonzero push without hit");

  // Requests are refused only behind a stalled result
  a_back_press: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without output stall");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(push_x_o) &&
    $stable(push_z_o) && $stable(hit_o))
    else $error("stalled result changed");

endmodule

bind circle_box_push_out cbpo_checker u_cbpo_checker (.*);
